/* rtl/lfcp_pkg.sv */
// ----------------------------------------------------------------------------
// lfcp_pkg: shared types and constants
// Types, keyword tables and controller commands of the laser frame command
// parser.
// ----------------------------------------------------------------------------
package lfcp_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int OUT_OFF_BITS    = 32;
  localparam int CODE_BITS       = 12;
  localparam int SPAN_BITS       = 16;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_LASER = 2'd0,
    ACT_X     = 2'd1,
    ACT_Y     = 2'd2,
    ACT_SEEK  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_SPAN      = 2'd0,
    REG_FULL      = 2'd1,
    REG_LASER_ON  = 2'd2,
    REG_LASER_OFF = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam int KW_START = 0;
  localparam int KW_ON    = 1;
  localparam int KW_OFF   = 2;
  localparam int KW_END   = 3;

  // Expected character of keyword k at position p, or 0 past the end.
  // The tables hold the ASCII text of each keyword, closing comma included.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
    logic [95:0] s;
    logic [3:0]  n;
    case (k)
      KW_START: begin s = 96'h6672616d655f73746172742c; n = 4'd12; end
      KW_ON:    begin s = {24'd0, 72'h6c617a65725f6f6e2c}; n = 4'd9; end
      KW_OFF:   begin s = {16'd0, 80'h6c617a65725f6f66662c}; n = 4'd10; end
      default:  begin s = {16'd0, 80'h6672616d655f656e642c}; n = 4'd10; end
    endcase
    if (p >= n) kw_char = 8'd0;
    else kw_char = s[8*(n - p - 4'd1) +: 8];
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      KW_START: kw_len = 4'd12;
      KW_ON:    kw_len = 4'd9;
      default:  kw_len = 4'd10;
    endcase
  endfunction

  // Datapath status seen by the controller when a byte arrives.
  typedef struct packed {
    logic is_comma;
    logic kw_start;
    logic kw_on;
    logic kw_off;
    logic kw_end;
    logic elapsed;
  } dp_status_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic take_item;   // update token state from the input item
    logic mul_start;   // capture magnitude * full scale
    logic div_step;    // one restoring division step
    logic div_init;    // load dividend
    logic emit_coord;  // load output from quotient
  } dp_cmd_t;

endpackage

/* rtl/lfcp_if.sv */
// ----------------------------------------------------------------------------
// lfcp_if: valid/ready channel
// Generic channel with a source and a sink modport.
// ----------------------------------------------------------------------------
interface lfcp_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/lfcp_ctrl.sv */
// ----------------------------------------------------------------------------
// lfcp_ctrl: controller
// Sequences item intake, the coordinate multiply and the serial divide.
// ----------------------------------------------------------------------------
module lfcp_ctrl #(
  parameter int DIV_STEPS = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_op,
  input  lfcp_pkg::dp_status_t  status,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output logic                  load_out,
  output lfcp_pkg::dp_cmd_t     cmd
);

  localparam int CW = $clog2(DIV_STEPS + 1);

  lfcp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfcp_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    logic acc;
    logic is_kw;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    load_out      = 1'b0;
    cmd           = '0;
    acc           = 1'b0;
    is_kw = status.kw_start || status.kw_on || status.kw_off || status.kw_end;
    case (state_r)
      lfcp_pkg::ST_IDLE: begin
        // Every item waits until the output is free.
        in_ready = !out_valid_nxt;
        acc = in_valid && in_ready;
        if (acc) begin
          cmd.take_item = 1'b1;
          if (in_op == lfcp_pkg::OP_BYTE && status.is_comma) begin
            if (!is_kw) begin
              cmd.mul_start = 1'b1;
              state_nxt = lfcp_pkg::ST_MUL;
            end else if (!status.kw_start && !(status.kw_end && status.elapsed)) begin
              load_out = 1'b1;
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      lfcp_pkg::ST_MUL: begin
        cmd.div_init = 1'b1;
        cnt_nxt = CW'(DIV_STEPS);
        state_nxt = lfcp_pkg::ST_DIV;
      end
      lfcp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = lfcp_pkg::ST_OUT;
      end
      lfcp_pkg::ST_OUT: begin
        cmd.emit_coord = 1'b1;
        load_out = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = lfcp_pkg::ST_IDLE;
      end
      default: state_nxt = lfcp_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/lfcp_dp.sv */
// ----------------------------------------------------------------------------
// lfcp_dp: datapath
// Token state, keyword match, number reader, multiply and serial divide.
// ----------------------------------------------------------------------------
module lfcp_dp #(
  parameter int OFFSET_BITS = lfcp_pkg::OFFSET_BITS_DEF,
  parameter int VALUE_BITS  = lfcp_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_op,
  input  logic [7:0]            in_byte_value,
  input  logic [31:0]           in_byte_offset,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  lfcp_pkg::dp_cmd_t     cmd,
  input  logic                  load_out,
  output lfcp_pkg::dp_status_t  status,
  output logic [1:0]            out_action,
  output logic [11:0]           out_dac_code,
  output logic [31:0]           out_seek_offset
);

  localparam int PW = VALUE_BITS + lfcp_pkg::CODE_BITS;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  logic [15:0] span_r;
  logic [11:0] full_r, lon_r, loff_r;
  logic [3:0]  len_r;
  logic [3:0]  match_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic        neg_r;
  logic [1:0]  phase_r;
  logic        axis_r;
  logic [OFFSET_BITS-1:0] fso_r;
  logic        elapsed_r;
  logic [PW-1:0] quo_r;   // dividend shifting into quotient
  logic [16:0]   rem_r;
  logic          zero_r;  // coordinate is negative and nonzero
  logic [1:0]    act_r;
  logic [11:0]   code_r;
  logic [31:0]   seek_r;

  logic [3:0] match_nxt;
  logic is_digit, is_ws;
  logic [VALUE_BITS+3:0] mag_ext;
  logic [3:0] len_p1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      match_nxt[k] = match_r[k] && (len_r < lfcp_pkg::kw_len(k)) &&
                     (lfcp_pkg::kw_char(k, len_r) == in_byte_value);
    end
  end

  assign len_p1 = len_r + 4'd1;
  assign is_digit = in_byte_value >= "0" && in_byte_value <= "9";
  assign is_ws = in_byte_value == 8'd32 || (in_byte_value >= 8'd9 && in_byte_value <= 8'd13);
  assign mag_ext = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} +
                   (VALUE_BITS+4)'(in_byte_value[3:0]);

  assign status.is_comma = in_byte_value == ",";
  assign status.kw_start = match_nxt[lfcp_pkg::KW_START] &&
                           len_p1 == lfcp_pkg::kw_len(lfcp_pkg::KW_START);
  assign status.kw_off = !status.kw_start && match_nxt[lfcp_pkg::KW_OFF] &&
                         len_p1 == lfcp_pkg::kw_len(lfcp_pkg::KW_OFF);
  assign status.kw_on = !status.kw_start && !status.kw_off && match_nxt[lfcp_pkg::KW_ON] &&
                        len_p1 == lfcp_pkg::kw_len(lfcp_pkg::KW_ON);
  assign status.kw_end = !status.kw_start && !status.kw_off && !status.kw_on &&
                         match_nxt[lfcp_pkg::KW_END] &&
                         len_p1 == lfcp_pkg::kw_len(lfcp_pkg::KW_END);
  assign status.elapsed = elapsed_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= 16'd480;
      full_r <= 12'd4095;
      lon_r  <= 12'd4095;
      loff_r <= 12'd0;
    end else if (cfg_we) begin
      case (lfcp_pkg::reg_idx_t'(cfg_index))
        lfcp_pkg::REG_SPAN:     span_r <= cfg_data;
        lfcp_pkg::REG_FULL:     full_r <= cfg_data[11:0];
        lfcp_pkg::REG_LASER_ON: lon_r  <= cfg_data[11:0];
        default:                loff_r <= cfg_data[11:0];
      endcase
    end
  end

  // Token and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; match_r <= '1; mag_r <= '0; neg_r <= 1'b0; phase_r <= '0;
      axis_r <= 1'b0; fso_r <= '0; elapsed_r <= 1'b0;
    end else if (cmd.take_item) begin
      case (lfcp_pkg::op_t'(in_op))
        lfcp_pkg::OP_TICK: elapsed_r <= 1'b1;
        lfcp_pkg::OP_RESTART: begin
          len_r <= '0; match_r <= '1; mag_r <= '0; neg_r <= 1'b0; phase_r <= '0;
          fso_r <= '0;
        end
        lfcp_pkg::OP_BYTE: begin
          if (status.is_comma) begin
            if (status.kw_start) fso_r <= OFFSET_BITS'(in_byte_offset) + OFFSET_BITS'(1);
            else if (status.kw_end && elapsed_r) elapsed_r <= 1'b0;
            else if (!status.kw_on && !status.kw_off && !status.kw_end) axis_r <= !axis_r;
            // The product register samples magnitude and sign at this same edge.
            len_r <= '0; match_r <= '1; phase_r <= '0; mag_r <= '0; neg_r <= 1'b0;
          end else begin
            match_r <= match_nxt;
            if (len_r != 4'd15) len_r <= len_p1;
            if (phase_r == 2'd0) begin
              if (is_ws) phase_r <= 2'd0;
              else if (in_byte_value == "-" || in_byte_value == "+") begin
                neg_r <= in_byte_value == "-"; phase_r <= 2'd1;
              end else if (is_digit) begin
                mag_r <= VALUE_BITS'(in_byte_value[3:0]); phase_r <= 2'd1;
              end else phase_r <= 2'd2;
            end else if (phase_r == 2'd1) begin
              if (is_digit) mag_r <= (mag_ext > (VALUE_BITS+4)'(VMAX)) ? VMAX
                                     : mag_ext[VALUE_BITS-1:0];
              else phase_r <= 2'd2;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Multiply, then a restoring divide one quotient bit per cycle.
  logic [16:0] span_eff, trial;
  assign span_eff = (span_r == 16'd0) ? 17'd1 : {1'b0, span_r};
  assign trial = {rem_r[15:0], quo_r[PW-1]} - span_eff;

  always_ff @(posedge clk) begin
    if (cmd.take_item && cmd.mul_start) begin
      quo_r  <= PW'(mag_r) * PW'(full_r);
      zero_r <= neg_r && mag_r != '0;
    end else if (cmd.div_init) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[16]) begin
        rem_r <= trial;
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], quo_r[PW-1]};
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cmd.emit_coord) begin
        // The axis flag already flipped when the comma was taken.
        act_r  <= axis_r ? lfcp_pkg::ACT_X : lfcp_pkg::ACT_Y;
        code_r <= zero_r ? 12'd0 : ((quo_r > PW'(4095)) ? 12'd4095 : quo_r[11:0]);
        seek_r <= '0;
      end else if (status.kw_end) begin
        act_r <= lfcp_pkg::ACT_SEEK; code_r <= '0; seek_r <= 32'(fso_r);
      end else begin
        act_r <= lfcp_pkg::ACT_LASER; code_r <= status.kw_on ? lon_r : loff_r; seek_r <= '0;
      end
    end
  end

  assign out_action = act_r;
  assign out_dac_code = code_r;
  assign out_seek_offset = seek_r;

endmodule

/* rtl/laser_frame_command_parser.sv */
// ----------------------------------------------------------------------------
// laser_frame_command_parser: top level
// Parses a comma-separated command stream into laser and DAC actions.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in_     | sink      | op, byte_value, byte_offset
// out_    | source    | action, dac_code, seek_offset
// cfg_    | sink      | index, data (span, full scale, on and off levels)
//
// A non-coordinate item is taken without entering the multiply and divide
// states. A coordinate token's closing comma keeps the input closed through
// them: the accepting cycle captures the product, ST_MUL loads the divider,
// one restoring divide step follows per product bit (VALUE_BITS+12), and
// ST_OUT loads the output register.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// all token and frame state. While a result waits on out_ready no new item is
// taken; the input opens again in the cycle in which the result is accepted.
module laser_frame_command_parser #(
  parameter int OFFSET_BITS = lfcp_pkg::OFFSET_BITS_DEF,
  parameter int VALUE_BITS  = lfcp_pkg::VALUE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  lfcp_if.sink   in_ch,
  lfcp_if.source out_ch,
  lfcp_if.sink   cfg_ch
);

  lfcp_pkg::dp_status_t status;
  lfcp_pkg::dp_cmd_t    cmd;
  logic                 load_out;

  // Configuration writes are always accepted.
  assign cfg_ch.ready = 1'b1;

  lfcp_ctrl #(.DIV_STEPS(VALUE_BITS + lfcp_pkg::CODE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.data[41:40]),
    .status    (status),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .load_out  (load_out),
    .cmd       (cmd)
  );

  lfcp_dp #(.OFFSET_BITS(OFFSET_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_ch.data[41:40]),
    .in_byte_value   (in_ch.data[39:32]),
    .in_byte_offset  (in_ch.data[31:0]),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.data[17:16]),
    .cfg_data        (cfg_ch.data[15:0]),
    .cmd             (cmd),
    .load_out        (load_out),
    .status          (status),
    .out_action      (out_ch.data[45:44]),
    .out_dac_code    (out_ch.data[43:32]),
    .out_seek_offset (out_ch.data[31:0])
  );

endmodule

/* rtl/lfcp_checker.sv */
// ----------------------------------------------------------------------------
// lfcp_checker: port checker
// Watches the top level's channels over time.
// ----------------------------------------------------------------------------
module lfcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [45:0] out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_seek_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[45:44] == 2'd3 |-> out_data[43:32] == 12'd0)
    else $error("seek carries a code");

  a_laser_no_seek: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[45:44] != 2'd3 |-> out_data[31:0] == 32'd0)
    else $error("non-seek carries an offset");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input open while a result waits");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind laser_frame_command_parser lfcp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data[45:0])
);
